>>> rtl/core/cpr_pkg.sv
// Package for the clock page replacement block: shared types, constants
// and the microcode ROM. No dependencies.
package cpr_pkg;

  localparam int MaxFrames = 16;
  localparam int PageBits  = 16;
  localparam int IdxBits   = 4;
  localparam int CntBits   = 5;
  localparam int FaultBits = 32;

  typedef logic [IdxBits-1:0]   idx_t;
  typedef logic [CntBits-1:0]   cnt_t;
  typedef logic [PageBits-1:0]  page_t;
  typedef logic [FaultBits-1:0] fault_t;
  typedef logic [2:0]           upc_t;

  localparam cnt_t FramesReset = cnt_t'(MaxFrames);

  // Micro-op driving the datapath
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LATCH,
    OP_SEARCH,
    OP_SWEEP,
    OP_PLACE,
    OP_HIT_SET,
    OP_EMIT
  } op_t;

  // Branch condition tested by the sequencer
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_BEAT,
    COND_HIT,
    COND_REF_CLR,
    COND_OUT_FREE
  } cond_t;

  // Program steps
  localparam upc_t UPC_WAIT   = 3'd0;
  localparam upc_t UPC_SEARCH = 3'd1;
  localparam upc_t UPC_BRANCH = 3'd2;
  localparam upc_t UPC_SWEEP  = 3'd3;
  localparam upc_t UPC_PLACE  = 3'd4;
  localparam upc_t UPC_HIT    = 3'd5;
  localparam upc_t UPC_EMIT   = 3'd6;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  tgt_true;
    upc_t  tgt_false;
  } ctrl_word_t;

  typedef struct packed {
    logic in_beat;
    logic hit;
    logic ref_clr;
    logic out_free;
  } status_t;

  function automatic ctrl_word_t ucode_rom(input upc_t upc);
    ctrl_word_t w;
    unique case (upc)
      UPC_WAIT:   w = '{OP_LATCH,   COND_IN_BEAT,  UPC_SEARCH, UPC_WAIT};
      UPC_SEARCH: w = '{OP_SEARCH,  COND_ALWAYS,   UPC_BRANCH, UPC_BRANCH};
      UPC_BRANCH: w = '{OP_NOP,     COND_HIT,      UPC_HIT,    UPC_SWEEP};
      // sweep holds while the bit under the pointer is set
      UPC_SWEEP:  w = '{OP_SWEEP,   COND_REF_CLR,  UPC_PLACE,  UPC_SWEEP};
      UPC_PLACE:  w = '{OP_PLACE,   COND_ALWAYS,   UPC_EMIT,   UPC_EMIT};
      UPC_HIT:    w = '{OP_HIT_SET, COND_ALWAYS,   UPC_EMIT,   UPC_EMIT};
      UPC_EMIT:   w = '{OP_EMIT,    COND_OUT_FREE, UPC_WAIT,   UPC_EMIT};
      default:    w = '{OP_NOP,     COND_ALWAYS,   UPC_WAIT,   UPC_WAIT};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/clock_page_replacement.sv
// Second-chance (clock) page replacement, top level.
// Instantiates cpr_sequencer and cpr_datapath; uses cpr_pkg.
//
// Input channel: in_valid / in_stall carry one page reference per beat.
// The block raises in_stall during reset and whenever its sequencer is not
// waiting for a new reference. Output channel: out_valid / out_stall, one
// result beat per reference (hit, frame, evicted page, saturating fault total).
// Config: cfg_valid / cfg_ready write frames_in_use; ready out of reset,
// write only while no reference is in flight.
// Steps: a hit goes through search, branch, hit and emit from accept to result
// loaded, then back to wait for the next reference. A fault goes through
// search, branch, sweep, place and emit; the sweep step clears the set
// reference bits the hand passes over, one frame per cycle (up to the effective
// frame count, frames_in_use clamped to 1..16), and stops on a clear one.
// The result sits in an output register, so the next reference is taken
// while it waits; if out_stall holds the register full, the sequencer
// waits in its emit step before loading the following result.
// Reset (rst_n low, synchronous): all frames empty, reference bits clear,
// hand at frame 0, fault total zero, frames_in_use 16, output empty.
module clock_page_replacement (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_page_number,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_frames_in_use,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [3:0]  out_frame_index,
  output logic        out_evicted_valid,
  output logic [15:0] out_evicted_page,
  output logic [31:0] out_fault_count
);

  cpr_pkg::ctrl_word_t ctrl;
  cpr_pkg::status_t    status;

  assign in_stall  = !rst_n || (ctrl.op != cpr_pkg::OP_LATCH);
  assign cfg_ready = rst_n;

  cpr_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  cpr_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .status            (status),
    .in_valid          (in_valid),
    .in_page_number    (in_page_number),
    .cfg_valid         (cfg_valid),
    .cfg_frames_in_use (cfg_frames_in_use),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count)
  );

endmodule

>>> rtl/core/cpr_sequencer.sv
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on cpr_pkg.
module cpr_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  cpr_pkg::status_t    status,
  output cpr_pkg::ctrl_word_t ctrl
);

  cpr_pkg::upc_t upc_r, upc_nxt;
  logic          take;

  assign ctrl = cpr_pkg::ucode_rom(upc_r);

  always_comb begin
    unique case (ctrl.cond)
      cpr_pkg::COND_ALWAYS:   take = 1'b1;
      cpr_pkg::COND_IN_BEAT:  take = status.in_beat;
      cpr_pkg::COND_HIT:      take = status.hit;
      cpr_pkg::COND_REF_CLR:  take = status.ref_clr;
      cpr_pkg::COND_OUT_FREE: take = status.out_free;
      default:                take = 1'b1;
    endcase
    upc_nxt = take ? ctrl.tgt_true : ctrl.tgt_false;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= cpr_pkg::UPC_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

>>> rtl/core/cpr_datapath.sv
// Datapath: frame table, reference bits, clock hand, fault total, config
// register and output register. Driven by cpr_sequencer; uses cpr_pkg.
module cpr_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  cpr_pkg::ctrl_word_t ctrl,
  output cpr_pkg::status_t    status,
  input  logic                in_valid,
  input  logic [15:0]         in_page_number,
  input  logic                cfg_valid,
  input  logic [4:0]          cfg_frames_in_use,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit,
  output logic [3:0]          out_frame_index,
  output logic                out_evicted_valid,
  output logic [15:0]         out_evicted_page,
  output logic [31:0]         out_fault_count
);

  localparam int N = cpr_pkg::MaxFrames;

  cpr_pkg::page_t  frame_page_r [N];
  logic [N-1:0]    occ_r;
  logic [N-1:0]    ref_r;
  cpr_pkg::idx_t   hand_r;
  cpr_pkg::fault_t fault_r;
  cpr_pkg::cnt_t   frames_r;

  cpr_pkg::page_t  page_r;
  cpr_pkg::idx_t   ptr_r;
  logic            hit_r;
  cpr_pkg::idx_t   hit_idx_r;

  logic            res_hit_r;
  cpr_pkg::idx_t   res_frame_r;
  logic            res_ev_valid_r;
  cpr_pkg::page_t  res_ev_page_r;

  logic            out_valid_r;
  logic            out_hit_r;
  cpr_pkg::idx_t   out_frame_r;
  logic            out_ev_valid_r;
  cpr_pkg::page_t  out_ev_page_r;
  cpr_pkg::fault_t out_fault_r;

  cpr_pkg::cnt_t   n_act;
  cpr_pkg::idx_t   hand_start;
  cpr_pkg::idx_t   ptr_wrap;
  logic            match_any;
  cpr_pkg::idx_t   match_idx;
  logic            out_free;
  logic            in_beat;

  // effective frame count, clamped to 1..MaxFrames
  always_comb begin
    if (frames_r == '0) begin
      n_act = cpr_pkg::cnt_t'(1);
    end else if (frames_r > cpr_pkg::cnt_t'(N)) begin
      n_act = cpr_pkg::cnt_t'(N);
    end else begin
      n_act = frames_r;
    end
  end

  assign hand_start = ({1'b0, hand_r} >= n_act) ? '0 : hand_r;
  assign ptr_wrap   = (({1'b0, ptr_r} + cpr_pkg::cnt_t'(1)) == n_act) ? '0
                      : ptr_r + cpr_pkg::idx_t'(1);

  // parallel tag compare over frames in range; lowest index wins
  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (occ_r[i] && (frame_page_r[i] == page_r) && (cpr_pkg::cnt_t'(i) < n_act)) begin
        match_any = 1'b1;
        match_idx = cpr_pkg::idx_t'(i);
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign in_beat  = in_valid && (ctrl.op == cpr_pkg::OP_LATCH);

  assign status.in_beat  = in_beat;
  assign status.hit      = hit_r;
  assign status.ref_clr  = !ref_r[ptr_r];
  assign status.out_free = out_free;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      ref_r       <= '0;
      hand_r      <= '0;
      fault_r     <= '0;
      frames_r    <= cpr_pkg::FramesReset;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        frames_r <= cfg_frames_in_use;
      end
      case (ctrl.op)
        cpr_pkg::OP_SWEEP: begin
          if (ref_r[ptr_r]) begin
            ref_r[ptr_r] <= 1'b0;
          end
        end
        cpr_pkg::OP_PLACE: begin
          occ_r[ptr_r] <= 1'b1;
          ref_r[ptr_r] <= 1'b1;
          hand_r       <= ptr_wrap;
          if (fault_r != '1) begin
            fault_r <= fault_r + cpr_pkg::fault_t'(1);
          end
        end
        cpr_pkg::OP_HIT_SET: begin
          ref_r[hit_idx_r] <= 1'b1;
        end
        default: ;
      endcase
      if (ctrl.op == cpr_pkg::OP_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (ctrl.op)
      cpr_pkg::OP_LATCH: begin
        if (in_beat) begin
          page_r <= in_page_number;
        end
      end
      cpr_pkg::OP_SEARCH: begin
        hit_r     <= match_any;
        hit_idx_r <= match_idx;
        ptr_r     <= hand_start;
      end
      cpr_pkg::OP_SWEEP: begin
        if (ref_r[ptr_r]) begin
          ptr_r <= ptr_wrap;
        end
      end
      cpr_pkg::OP_PLACE: begin
        frame_page_r[ptr_r] <= page_r;
        res_hit_r           <= 1'b0;
        res_frame_r         <= ptr_r;
        res_ev_valid_r      <= occ_r[ptr_r];
        res_ev_page_r       <= occ_r[ptr_r] ? frame_page_r[ptr_r] : '0;
      end
      cpr_pkg::OP_HIT_SET: begin
        res_hit_r      <= 1'b1;
        res_frame_r    <= hit_idx_r;
        res_ev_valid_r <= 1'b0;
        res_ev_page_r  <= '0;
      end
      cpr_pkg::OP_EMIT: begin
        if (out_free) begin
          out_hit_r      <= res_hit_r;
          out_frame_r    <= res_frame_r;
          out_ev_valid_r <= res_ev_valid_r;
          out_ev_page_r  <= res_ev_page_r;
          out_fault_r    <= fault_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_index   = out_frame_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_count   = out_fault_r;

endmodule
